// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the colour adjust checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked across reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/cadj_pkg.sv =====
// ---------------------------------------------------------------------------
// Colour adjust package
// Types, register indexes and constant tables shared by the colour adjust.
// ---------------------------------------------------------------------------
package cadj_pkg;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_BRIGHTNESS = 2'd0,
        REG_CONTRAST   = 2'd1,
        REG_GAMMA      = 2'd2
    } cadj_reg_t;

    localparam int BRIGHT_W = 17;
    localparam int GAIN_W   = 18;
    localparam int CFG_W    = 18;
    localparam logic [GAIN_W-1:0] UNITY = 18'h10000;

    // Settings as the channel datapath sees them.
    typedef struct packed {
        logic [8:0]        offset;   // signed brightness offset
        logic [GAIN_W-1:0] contrast;
        logic              gamma_up;
        logic              gamma_dn;
    } cadj_cfg_t;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
        logic st4;
    } cadj_adv_t;

    typedef logic [7:0] expand_lut_t [32];
    typedef logic [5:0] narrow_lut_t [256];

    // Five-bit channel widened to eight bits, truncating.
    function automatic expand_lut_t build_expand_lut();
        expand_lut_t lut;
        for (int i = 0; i < 32; i++) begin
            lut[i] = 8'(i * 255 / 31);
        end
        return lut;
    endfunction

    // Eight-bit channel narrowed to the output width, truncating.
    function automatic narrow_lut_t build_narrow_lut(input int top);
        narrow_lut_t lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = 6'(i * top / 255);
        end
        return lut;
    endfunction

    localparam expand_lut_t EXPAND_LUT   = build_expand_lut();
    localparam narrow_lut_t NARROW5_LUT  = build_narrow_lut(31);
    localparam narrow_lut_t NARROW6_LUT  = build_narrow_lut(63);

endpackage

// ===== rtl/rgb555_to_rgb565_color_adjust.sv =====
// ---------------------------------------------------------------------------
// RGB555 to RGB565 colour adjust
// Converts a stream of 15-bit colours to 5-6-5 with brightness, contrast
// and gamma adjustment applied to each channel.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel takes one 15-bit colour per word, the master channel
//   gives one 5-6-5 colour per word, in the same order.
//   Brightness, contrast and gamma are written through the configuration
//   port (index 0, 1, 2) while no word is in flight; all reset to unity.
//   The result reaches m_tvalid through the four register stages of each
//   channel datapath: widen plus offset, contrast multiply, gamma step
//   plus clamp, narrow. While the receiver keeps up, throughput is one
//   word per cycle; each stage holds its own valid bit. When the receiver
//   stalls, the result stays on m_tdata, the stages behind it keep
//   filling any empty slot, and s_tready falls only once all four
//   stages are full.
//   Reset clears the stage valid bits and the registers to unity.
// ---------------------------------------------------------------------------
module rgb555_to_rgb565_color_adjust (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration port
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [cadj_pkg::CFG_W-1:0] cfg_wdata,
    // Input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // [14:0] color_in, [15] zero
    // Result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata    // [15:0] color_out
);
    import cadj_pkg::*;

    cadj_cfg_t cfg;
    cadj_adv_t adv;

    logic [3:0] valid_reg, valid_next;
    logic [3:0] ready;
    logic [4:0] red;
    logic [5:0] green;
    logic [4:0] blue;

    // Register bank.
    cadj_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // A stage may load when it is empty or the stage after it moves on.
    always_comb begin
        ready[3] = !valid_reg[3] || m_tready;
        ready[2] = !valid_reg[2] || ready[3];
        ready[1] = !valid_reg[1] || ready[2];
        ready[0] = !valid_reg[0] || ready[1];
        adv.st1  = ready[0] && s_tvalid;
        adv.st2  = ready[1] && valid_reg[0];
        adv.st3  = ready[2] && valid_reg[1];
        adv.st4  = ready[3] && valid_reg[2];
    end

    // Valid bits travel alongside the datapath.
    always_comb begin
        valid_next = valid_reg;
        if (ready[0]) begin
            valid_next[0] = s_tvalid;
        end
        if (ready[1]) begin
            valid_next[1] = valid_reg[0];
        end
        if (ready[2]) begin
            valid_next[2] = valid_reg[1];
        end
        if (ready[3]) begin
            valid_next[3] = valid_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 4'b0000;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // One datapath per channel.
    cadj_channel #(.GREEN(1'b0)) u_red (
        .aclk     (aclk),
        .chan_in  (s_tdata[4:0]),
        .cfg      (cfg),
        .adv      (adv),
        .chan_out (red)
    );

    cadj_channel #(.GREEN(1'b1)) u_green (
        .aclk     (aclk),
        .chan_in  (s_tdata[9:5]),
        .cfg      (cfg),
        .adv      (adv),
        .chan_out (green)
    );

    cadj_channel #(.GREEN(1'b0)) u_blue (
        .aclk     (aclk),
        .chan_in  (s_tdata[14:10]),
        .cfg      (cfg),
        .adv      (adv),
        .chan_out (blue)
    );

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[3];
    assign m_tdata  = {red, green, blue};

endmodule

// ===== rtl/cadj_cfg.sv =====
// ---------------------------------------------------------------------------
// Colour adjust configuration
// Holds brightness, contrast and gamma and derives the per-channel settings.
// ---------------------------------------------------------------------------
module cadj_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [cadj_pkg::CFG_W-1:0] cfg_wdata,
    output cadj_pkg::cadj_cfg_t        cfg
);
    import cadj_pkg::*;

    logic [BRIGHT_W-1:0] brightness_reg, brightness_next;
    logic [GAIN_W-1:0]   contrast_reg, contrast_next;
    logic [GAIN_W-1:0]   gamma_reg, gamma_next;

    // Register write decode; unknown indexes are ignored.
    always_comb begin
        brightness_next = brightness_reg;
        contrast_next   = contrast_reg;
        gamma_next      = gamma_reg;
        if (cfg_wr_en) begin
            unique case (cadj_reg_t'(cfg_index))
                REG_BRIGHTNESS: brightness_next = cfg_wdata[BRIGHT_W-1:0];
                REG_CONTRAST:   contrast_next   = cfg_wdata[GAIN_W-1:0];
                REG_GAMMA:      gamma_next      = cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHT_W'(UNITY);
            contrast_reg   <= UNITY;
            gamma_reg      <= UNITY;
        end else begin
            brightness_reg <= brightness_next;
            contrast_reg   <= contrast_next;
            gamma_reg      <= gamma_next;
        end
    end

    // Subtracting unity flips the top bit; the floored shift by eight
    // then keeps bits 16 to 8 as a signed offset.
    always_comb begin
        cfg.offset   = {~brightness_reg[16], brightness_reg[15:8]};
        cfg.contrast = contrast_reg;
        cfg.gamma_up = (gamma_reg > UNITY);
        cfg.gamma_dn = (gamma_reg < UNITY);
    end

endmodule

// ===== rtl/cadj_channel.sv =====
// ---------------------------------------------------------------------------
// Colour adjust channel
// Four-stage datapath for one colour channel: widen and offset, scale,
// gamma step and clamp, narrow.
// ---------------------------------------------------------------------------
module cadj_channel #(
    parameter bit GREEN = 1'b0
) (
    input  logic                          aclk,
    input  logic [4:0]                    chan_in,
    input  cadj_pkg::cadj_cfg_t           cfg,
    input  cadj_pkg::cadj_adv_t           adv,
    output logic [(GREEN ? 6 : 5)-1:0]    chan_out
);
    import cadj_pkg::*;

    localparam int OUT_W = GREEN ? 6 : 5;

    logic signed [9:0]  sum_reg, sum_next;
    logic signed [28:0] prod_reg, prod_next;
    logic [7:0]         sat_reg, sat_next;
    logic [OUT_W-1:0]   out_reg, out_next;

    logic signed [12:0] scaled;
    logic signed [12:0] adj;
    logic               in_band;
    logic [5:0]         narrow;

    // Stage 1: widen to eight bits and add the brightness offset.
    always_comb begin
        sum_next = $signed({2'b00, EXPAND_LUT[chan_in]})
                 + $signed({cfg.offset[8], cfg.offset});
    end

    // Stage 2: contrast gain as a signed product.
    always_comb begin
        prod_next = $signed({{19{sum_reg[9]}}, sum_reg})
                  * $signed({11'b0, cfg.contrast});
    end

    // Stage 3: floored shift by sixteen, gamma step in the mid band, clamp.
    always_comb begin
        scaled  = $signed(prod_reg[28:16]);
        in_band = (scaled > 13'sd64) && (scaled < 13'sd192);
        adj     = scaled;
        if (in_band && cfg.gamma_up) begin
            adj = scaled + 13'sd16;
        end else if (in_band && cfg.gamma_dn) begin
            adj = scaled - 13'sd16;
        end
        if (adj[12]) begin
            sat_next = 8'h00;
        end else if (adj > 13'sd255) begin
            sat_next = 8'hFF;
        end else begin
            sat_next = adj[7:0];
        end
    end

    // Stage 4: narrow to the output channel width.
    always_comb begin
        narrow   = GREEN ? NARROW6_LUT[sat_reg] : NARROW5_LUT[sat_reg];
        out_next = narrow[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv.st1) begin
            sum_reg <= sum_next;
        end
        if (adv.st2) begin
            prod_reg <= prod_next;
        end
        if (adv.st3) begin
            sat_reg <= sat_next;
        end
        if (adv.st4) begin
            out_reg <= out_next;
        end
    end

    assign chan_out = out_reg;

endmodule

// ===== rtl/cadj_checker.sv =====
// ---------------------------------------------------------------------------
// Colour adjust checker
// Port-level checks of the colour adjust stream behaviour.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cadj_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // No result is pending straight after reset.
    `ASSERT_CLK(a_reset_empty, aclk, $rose(aresetn) |-> !m_tvalid, "result valid after reset")

    // A stalled result holds its word.
    `ASSERT_CLK_RST(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // With the receiver ready the pipeline never blocks the input.
    `ASSERT_CLK_RST(a_flow, aclk, aresetn, m_tready |-> s_tready, "input blocked while output drains")

    // An accepted word reaches the output while the receiver stays ready.
    `ASSERT_CLK_RST(a_latency, aclk, aresetn, (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid, "result missing after four cycles")

endmodule

bind rgb555_to_rgb565_color_adjust cadj_checker u_cadj_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
